[hdl/cpc_pkg.sv]
// cpc_pkg: shared types and constants for the clipped paste compositor.
// No dependencies; used by cpc_blend and clipped_paste_compositor in hdl/.
package cpc_pkg;

    // input word kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_PASTE = 2'd2;

    // blend modes
    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_ALPHA = 2'd1;
    localparam logic [1:0] MODE_SMASK = 2'd2;
    localparam logic [1:0] MODE_CMASK = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_DEST_WIDTH   = 3'd0;
    localparam logic [2:0] REG_DEST_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_SOURCE_WIDTH = 3'd2;
    localparam logic [2:0] REG_OFFSET_X     = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y     = 3'd4;
    localparam logic [2:0] REG_BLEND_MODE   = 3'd5;
    localparam logic [2:0] REG_FILL_COLOR   = 3'd6;
    localparam logic [2:0] REG_ALPHA        = 3'd7;

    localparam logic [12:0] ROW_LIMIT = 13'd8191;
    localparam logic [12:0] COL_LIMIT = 13'd4096;
    localparam logic [7:0]  CHAN_MAX  = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_MUL,
        ST_WB,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  alpha;
        logic [23:0] fill;
    } blend_cfg_t;

endpackage

[hdl/cpc_blend.sv]
// cpc_blend: per-channel weighted mix (keep*(255-w) + take*w)/255, truncating.
// Products are registered on load; the divide by 255 follows combinationally.
// Depends on cpc_pkg.
module cpc_blend (
    input  logic                aclk,
    input  logic                load,
    input  cpc_pkg::blend_cfg_t cfg,
    input  logic [23:0]         src,
    input  logic [23:0]         mask,
    input  logic [23:0]         dst,
    output logic [23:0]         res
);

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [7:0]  keep;
        logic [7:0]  take;
        logic [7:0]  wgt;
        logic [15:0] sum_next;
        logic [15:0] sum_reg;
        logic [15:0] qtmp;

        always_comb begin
            case (cfg.mode)
                cpc_pkg::MODE_COPY: begin
                    // src*255/255 == src
                    keep = src[8*c +: 8];
                    take = dst[8*c +: 8];
                    wgt  = 8'd0;
                end
                cpc_pkg::MODE_ALPHA: begin
                    keep = src[8*c +: 8];
                    take = dst[8*c +: 8];
                    wgt  = cfg.alpha;
                end
                cpc_pkg::MODE_SMASK: begin
                    keep = dst[8*c +: 8];
                    take = src[8*c +: 8];
                    wgt  = mask[8*c +: 8];
                end
                default: begin
                    keep = dst[8*c +: 8];
                    take = cfg.fill[8*c +: 8];
                    wgt  = mask[8*c +: 8];
                end
            endcase
            sum_next = ({8'd0, keep} * {8'd0, cpc_pkg::CHAN_MAX - wgt})
                       + ({8'd0, take} * {8'd0, wgt});
        end

        always_ff @(posedge aclk) begin
            if (load) begin
                sum_reg <= sum_next;
            end
        end

        // exact x/255 for x < 65280
        assign qtmp = sum_reg + 16'd1 + {8'd0, sum_reg[15:8]};
        assign res[8*c +: 8] = qtmp[15:8];
    end

endmodule

[hdl/clipped_paste_compositor.sv]
// Clipped paste compositor: RGB frame store with pixel write/read and a blended,
// clipped raster paste stream. Depends on cpc_pkg and cpc_blend.
//
// Usage:
//   s_ channel carries one word per operation: write pixel, read pixel or one
//   paste source pixel (tuser.first restarts the paste stream at column 0, row 0).
//   m_ channel returns exactly one word per input word: read colors, landed flag
//   for paste pixels that fell inside the destination, status for out-of-range
//   write/read positions. Registers are written over the APB port by the user, who
//   must do so only while the block is idle; the block itself does not enforce it.
// Timing:
//   Each word passes address, frame-memory read, multiply, write-back and output
//   stages, with one word in flight because of the read-modify-write on the single
//   frame memory port: a new word is accepted only after the last leaves the output
//   stage. The result is registered at write-back and again in the output register.
//   The output register frees the core; if m_tready is low the finished result
//   waits in the core until the output register empties, and s_tready stays low.
// Reset:
//   aresetn (synchronous, active low) clears the handshakes, the stream position
//   and restores register defaults; frame memory contents are undefined until
//   written. No clearing pass is run.
module clipped_paste_compositor #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x, pos_y, red, green, blue, mask_red, mask_green, mask_blue
    input  logic [63:0] s_tdata,
    // kind[1:0], first[2]
    input  logic [2:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_red, read_green, read_blue
    output logic [23:0] m_tdata,
    // landed[0], status[1]
    output logic [1:0]  m_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
    localparam logic [12:0]   MAXW       = 13'(MAX_WIDTH);
    localparam logic [12:0]   MAXH       = 13'(MAX_HEIGHT);

    // configuration registers
    logic [8:0]  dest_width_reg;
    logic [8:0]  dest_height_reg;
    logic [12:0] source_width_reg;
    logic [12:0] offset_x_reg;
    logic [12:0] offset_y_reg;
    logic [1:0]  blend_mode_reg;
    logic [23:0] fill_color_reg;
    logic [7:0]  alpha_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_width_reg   <= 9'd256;
            dest_height_reg  <= 9'd256;
            source_width_reg <= 13'd1;
            offset_x_reg     <= 13'd0;
            offset_y_reg     <= 13'd0;
            blend_mode_reg   <= cpc_pkg::MODE_COPY;
            fill_color_reg   <= 24'd0;
            alpha_reg        <= 8'd0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                cpc_pkg::REG_DEST_WIDTH:   dest_width_reg   <= pwdata[8:0];
                cpc_pkg::REG_DEST_HEIGHT:  dest_height_reg  <= pwdata[8:0];
                cpc_pkg::REG_SOURCE_WIDTH: source_width_reg <= pwdata[12:0];
                cpc_pkg::REG_OFFSET_X:     offset_x_reg     <= pwdata[12:0];
                cpc_pkg::REG_OFFSET_Y:     offset_y_reg     <= pwdata[12:0];
                cpc_pkg::REG_BLEND_MODE:   blend_mode_reg   <= pwdata[1:0];
                cpc_pkg::REG_FILL_COLOR:   fill_color_reg   <= pwdata[23:0];
                cpc_pkg::REG_ALPHA:        alpha_reg        <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            cpc_pkg::REG_DEST_WIDTH:   prdata = {23'd0, dest_width_reg};
            cpc_pkg::REG_DEST_HEIGHT:  prdata = {23'd0, dest_height_reg};
            cpc_pkg::REG_SOURCE_WIDTH: prdata = {19'd0, source_width_reg};
            cpc_pkg::REG_OFFSET_X:     prdata = {19'd0, offset_x_reg};
            cpc_pkg::REG_OFFSET_Y:     prdata = {19'd0, offset_y_reg};
            cpc_pkg::REG_BLEND_MODE:   prdata = {30'd0, blend_mode_reg};
            cpc_pkg::REG_FILL_COLOR:   prdata = {8'd0, fill_color_reg};
            cpc_pkg::REG_ALPHA:        prdata = {24'd0, alpha_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // effective geometry
    logic [12:0] w_eff;
    logic [12:0] h_eff;
    logic [12:0] sw_eff;
    assign w_eff = ({4'd0, dest_width_reg} > MAXW) ? MAXW : {4'd0, dest_width_reg};
    assign h_eff = ({4'd0, dest_height_reg} > MAXH) ? MAXH : {4'd0, dest_height_reg};
    always_comb begin
        if (source_width_reg == 13'd0) begin
            sw_eff = 13'd1;
        end else if (source_width_reg > cpc_pkg::COL_LIMIT) begin
            sw_eff = cpc_pkg::COL_LIMIT;
        end else begin
            sw_eff = source_width_reg;
        end
    end

    // sequencer
    cpc_pkg::state_t state_reg, state_next;
    logic            out_free;
    logic            s_accept;
    logic            mem_rd_en;
    logic            mul_load;

    assign out_free = !m_tvalid || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cpc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_rd_en  = 1'b0;
        mul_load   = 1'b0;
        case (state_reg)
            cpc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = cpc_pkg::ST_ADDR;
                end
            end
            cpc_pkg::ST_ADDR: state_next = cpc_pkg::ST_READ;
            cpc_pkg::ST_READ: begin
                mem_rd_en  = 1'b1;
                state_next = cpc_pkg::ST_MUL;
            end
            cpc_pkg::ST_MUL: begin
                mul_load   = 1'b1;
                state_next = cpc_pkg::ST_WB;
            end
            cpc_pkg::ST_WB: state_next = cpc_pkg::ST_OUT;
            cpc_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = cpc_pkg::ST_IDLE;
                end
            end
            default: state_next = cpc_pkg::ST_IDLE;
        endcase
    end

    // latched word
    logic [1:0]  kind_reg;
    logic [7:0]  px_reg;
    logic [7:0]  py_reg;
    logic [23:0] src_reg;
    logic [23:0] mask_reg;
    logic        first_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg  <= s_tuser[1:0];
            first_reg <= s_tuser[2];
            px_reg    <= s_tdata[7:0];
            py_reg    <= s_tdata[15:8];
            src_reg   <= {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
            mask_reg  <= {s_tdata[47:40], s_tdata[55:48], s_tdata[63:56]};
        end
    end

    // address stage: position, clipping and stream advance
    logic [11:0]   col_reg, col_next, col_cur;
    logic [12:0]   row_reg, row_next, row_cur;
    logic [12:0]   col_inc;
    logic [13:0]   dx;
    logic [14:0]   dy;
    logic          hit_next, hit_reg;
    logic [XW-1:0] x_sel;
    logic [YW-1:0] y_sel;
    logic [AW-1:0] addr_next, addr_reg;

    assign col_cur = first_reg ? 12'd0 : col_reg;
    assign row_cur = first_reg ? 13'd0 : row_reg;
    assign dx      = {offset_x_reg[12], offset_x_reg} + {2'd0, col_cur};
    assign dy      = {{2{offset_y_reg[12]}}, offset_y_reg} + {2'd0, row_cur};
    assign col_inc = {1'b0, col_cur} + 13'd1;

    always_comb begin
        if (col_inc >= sw_eff) begin
            col_next = 12'd0;
            row_next = (row_cur < cpc_pkg::ROW_LIMIT) ? row_cur + 13'd1 : row_cur;
        end else begin
            col_next = col_inc[11:0];
            row_next = row_cur;
        end
    end

    always_comb begin
        hit_next = 1'b0;
        x_sel    = XW'(px_reg);
        y_sel    = YW'(py_reg);
        case (kind_reg)
            cpc_pkg::KIND_WRITE, cpc_pkg::KIND_READ: begin
                hit_next = ({5'd0, px_reg} < w_eff) && ({5'd0, py_reg} < h_eff);
            end
            cpc_pkg::KIND_PASTE: begin
                hit_next = !dx[13] && (dx[12:0] < w_eff) && !dy[14] && (dy[13:0] < {1'b0, h_eff});
                x_sel    = XW'(dx[12:0]);
                y_sel    = YW'(dy[13:0]);
            end
            default: hit_next = 1'b0;
        endcase
        addr_next = AW'(x_sel) + AW'(y_sel) * ROW_STRIDE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 12'd0;
            row_reg <= 13'd0;
        end else if (state_reg == cpc_pkg::ST_ADDR && kind_reg == cpc_pkg::KIND_PASTE) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == cpc_pkg::ST_ADDR) begin
            hit_reg  <= hit_next;
            addr_reg <= addr_next;
        end
    end

    // frame memory, registered read
    logic [23:0] frame_mem [DEPTH];
    logic [23:0] rd_data_reg;
    logic        mem_we;
    logic [23:0] mem_wdata;
    logic [23:0] blend_res;

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            rd_data_reg <= frame_mem[addr_reg];
        end
        if (mem_we) begin
            frame_mem[addr_reg] <= mem_wdata;
        end
    end

    cpc_pkg::blend_cfg_t blend_cfg;
    assign blend_cfg.mode  = blend_mode_reg;
    assign blend_cfg.alpha = alpha_reg;
    assign blend_cfg.fill  = fill_color_reg;

    cpc_blend u_blend (
        .aclk (aclk),
        .load (mul_load),
        .cfg  (blend_cfg),
        .src  (src_reg),
        .mask (mask_reg),
        .dst  (rd_data_reg),
        .res  (blend_res)
    );

    // write-back and result
    logic        is_rw;
    logic [23:0] res_data_reg;
    logic [1:0]  res_user_reg;

    assign is_rw     = (kind_reg == cpc_pkg::KIND_WRITE) || (kind_reg == cpc_pkg::KIND_READ);
    assign mem_we    = (state_reg == cpc_pkg::ST_WB) && hit_reg
                       && ((kind_reg == cpc_pkg::KIND_WRITE) || (kind_reg == cpc_pkg::KIND_PASTE));
    assign mem_wdata = (kind_reg == cpc_pkg::KIND_WRITE) ? src_reg : blend_res;

    always_ff @(posedge aclk) begin
        if (state_reg == cpc_pkg::ST_WB) begin
            res_data_reg <= (kind_reg == cpc_pkg::KIND_READ && hit_reg) ? rd_data_reg : 24'd0;
            res_user_reg <= {is_rw && !hit_reg, (kind_reg == cpc_pkg::KIND_PASTE) && hit_reg};
        end
    end

    // output register; internal pixel order is red high, tdata puts red lowest
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == cpc_pkg::ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == cpc_pkg::ST_OUT && out_free) begin
            m_tdata_reg <= {res_data_reg[7:0], res_data_reg[15:8], res_data_reg[23:16]};
            m_tuser_reg <= res_user_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[hdl/cpc_checker.sv]
// cpc_checker: port-level assertions for clipped_paste_compositor, bound to the top.
// Depends only on the top level's port names.
module cpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one word in flight: no acceptance on the following cycle
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("landed and status both set");

    // colors only come from in-range reads
    a_colors_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata == 24'd0)
        else $error("colors nonzero on paste or error word");

endmodule

bind clipped_paste_compositor cpc_checker u_cpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
